### rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/tlqe_pkg.sv
// Types and constants of the thick line quad expander.
// No dependencies; every RTL module imports it.
package tlqe_pkg;

  localparam int Q_DEPTH    = 16;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int CNT_W      = $clog2(Q_DEPTH + 1);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int N_VERTS    = 6;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [30:0]        thickness;
    logic [31:0]        color_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        color_out;
    logic               degenerate;
    logic               last_vertex;
  } out_item_t;

  // Segment context carried alongside the offset arithmetic.
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic [31:0]        color;
    logic               degen;
    logic               negx;
    logic               negy;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [62:0] sum;
    logic [61:0] px;
    logic [61:0] py;
  } sq_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [31:0] len;
    logic [61:0] px;
    logic [61:0] py;
  } rt_t;

  // Queue entry: ready for vertex emission.
  typedef struct packed {
    ctx_t               ctx;
    logic signed [31:0] mx;
    logic signed [31:0] my;
  } seg_t;

endpackage

### rtl/tlqe_front.sv
// Front end: difference, magnitude, range fold, squares and thickness products.
// Depends on tlqe_pkg.
module tlqe_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  tlqe_pkg::in_item_t in_item,
  output logic             sq_valid,
  output tlqe_pkg::sq_t    sq_out
);
  import tlqe_pkg::*;

  logic        s1_valid_r, s2_valid_r, s3_valid_r;
  ctx_t        s1_ctx_r, s2_ctx_r, s3_ctx_r;
  logic [30:0] s1_ax_r, s1_ay_r, s1_t_r;
  logic [61:0] s2_xx_r, s2_yy_r, s2_px_r, s2_py_r;
  logic [61:0] s3_px_r, s3_py_r;
  logic [62:0] s3_sum_r;

  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic               big;
  ctx_t               ctx_nxt;

  always_comb begin
    dx  = {in_item.end_x[31], in_item.end_x} - {in_item.start_x[31], in_item.start_x};
    dy  = {in_item.end_y[31], in_item.end_y} - {in_item.start_y[31], in_item.start_y};
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    ay  = dy[32] ? 33'(-dy) : 33'(dy);
    big = ax[32] | ax[31] | ay[32] | ay[31];
    ctx_nxt.sx    = in_item.start_x;
    ctx_nxt.sy    = in_item.start_y;
    ctx_nxt.ex    = in_item.end_x;
    ctx_nxt.ey    = in_item.end_y;
    ctx_nxt.color = in_item.color_in;
    ctx_nxt.degen = (dx == '0) && (dy == '0);
    ctx_nxt.negx  = dx[32];
    ctx_nxt.negy  = dy[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctx_r <= ctx_nxt;
    // fold large differences down one bit so the squares fit
    s1_ax_r  <= big ? ax[31:1] : ax[30:0];
    s1_ay_r  <= big ? ay[31:1] : ay[30:0];
    s1_t_r   <= in_item.thickness;
    s2_ctx_r <= s1_ctx_r;
    s2_xx_r  <= s1_ax_r * s1_ax_r;
    s2_yy_r  <= s1_ay_r * s1_ay_r;
    s2_px_r  <= s1_ax_r * s1_t_r;
    s2_py_r  <= s1_ay_r * s1_t_r;
    s3_ctx_r <= s2_ctx_r;
    s3_sum_r <= {1'b0, s2_xx_r} + {1'b0, s2_yy_r};
    s3_px_r  <= s2_px_r;
    s3_py_r  <= s2_py_r;
  end

  assign sq_valid   = s3_valid_r;
  assign sq_out.ctx = s3_ctx_r;
  assign sq_out.sum = s3_sum_r;
  assign sq_out.px  = s3_px_r;
  assign sq_out.py  = s3_py_r;
endmodule

### rtl/tlqe_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tlqe_pkg.
module tlqe_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sq_valid,
  input  tlqe_pkg::sq_t sq_in,
  output logic          rt_valid,
  output tlqe_pkg::rt_t rt_out
);
  import tlqe_pkg::*;

  logic        vld_r  [SQRT_STEPS+1];
  logic [62:0] v_r    [SQRT_STEPS+1];
  logic [62:0] r_r    [SQRT_STEPS+1];
  ctx_t        ctx_r  [SQRT_STEPS+1];
  logic [61:0] px_r   [SQRT_STEPS+1];
  logic [61:0] py_r   [SQRT_STEPS+1];

  always_comb begin
    vld_r[0] = sq_valid;
    v_r[0]   = sq_in.sum;
    r_r[0]   = '0;
    ctx_r[0] = sq_in.ctx;
    px_r[0]  = sq_in.px;
    py_r[0]  = sq_in.py;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] B = 64'd1 << (62 - 2 * i);
    logic [63:0] t;
    logic        ge;
    always_comb begin
      t  = {1'b0, r_r[i]} + B;
      ge = {1'b0, v_r[i]} >= t;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      v_r[i+1]   <= ge ? (v_r[i] - t[62:0]) : v_r[i];
      r_r[i+1]   <= ge ? ((r_r[i] >> 1) + B[62:0]) : (r_r[i] >> 1);
      ctx_r[i+1] <= ctx_r[i];
      px_r[i+1]  <= px_r[i];
      py_r[i+1]  <= py_r[i];
    end
  end

  assign rt_valid   = vld_r[SQRT_STEPS];
  assign rt_out.ctx = ctx_r[SQRT_STEPS];
  assign rt_out.len = r_r[SQRT_STEPS][31:0];
  assign rt_out.px  = px_r[SQRT_STEPS];
  assign rt_out.py  = py_r[SQRT_STEPS];
endmodule

### rtl/tlqe_div.sv
// Pipelined restoring divider for both offset components, rounding half up.
// Depends on tlqe_pkg.
module tlqe_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rt_valid,
  input  tlqe_pkg::rt_t  rt_in,
  output logic           seg_valid,
  output tlqe_pkg::seg_t seg_out
);
  import tlqe_pkg::*;

  logic        e_valid_r;
  ctx_t        e_ctx_r;
  logic [62:0] e_nx_r, e_ny_r;
  logic [32:0] e_den_r;

  logic        vld_r [DIV_STEPS+1];
  ctx_t        ctx_r [DIV_STEPS+1];
  logic [32:0] den_r [DIV_STEPS+1];
  logic [32:0] remx_r[DIV_STEPS+1];
  logic [32:0] remy_r[DIV_STEPS+1];
  logic [30:0] nx_r  [DIV_STEPS+1];
  logic [30:0] ny_r  [DIV_STEPS+1];
  logic [30:0] qx_r  [DIV_STEPS+1];
  logic [30:0] qy_r  [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else        e_valid_r <= rt_valid;
  end

  // add half the divisor for round half up
  always_ff @(posedge clk) begin
    e_ctx_r <= rt_in.ctx;
    e_nx_r  <= {1'b0, rt_in.px} + {31'd0, rt_in.len};
    e_ny_r  <= {1'b0, rt_in.py} + {31'd0, rt_in.len};
    e_den_r <= {rt_in.len, 1'b0};
  end

  always_comb begin
    vld_r[0]  = e_valid_r;
    ctx_r[0]  = e_ctx_r;
    den_r[0]  = e_den_r;
    remx_r[0] = {1'b0, e_nx_r[62:31]};
    remy_r[0] = {1'b0, e_ny_r[62:31]};
    nx_r[0]   = e_nx_r[30:0];
    ny_r[0]   = e_ny_r[30:0];
    qx_r[0]   = '0;
    qy_r[0]   = '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [33:0] cx, cy;
    logic        gx, gy;
    always_comb begin
      cx = {remx_r[j], nx_r[j][DIV_STEPS-1-j]};
      cy = {remy_r[j], ny_r[j][DIV_STEPS-1-j]};
      gx = cx >= {1'b0, den_r[j]};
      gy = cy >= {1'b0, den_r[j]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j+1] <= 1'b0;
      else        vld_r[j+1] <= vld_r[j];
    end
    always_ff @(posedge clk) begin
      ctx_r[j+1]  <= ctx_r[j];
      den_r[j+1]  <= den_r[j];
      nx_r[j+1]   <= nx_r[j];
      ny_r[j+1]   <= ny_r[j];
      remx_r[j+1] <= gx ? 33'(cx - {1'b0, den_r[j]}) : cx[32:0];
      remy_r[j+1] <= gy ? 33'(cy - {1'b0, den_r[j]}) : cy[32:0];
      qx_r[j+1]   <= {qx_r[j][29:0], gx};
      qy_r[j+1]   <= {qy_r[j][29:0], gy};
    end
  end

  logic [31:0] magx, magy;

  always_comb begin
    // zero-length segment has a zero divisor: drop the quotient
    magx = ctx_r[DIV_STEPS].degen ? '0 : {1'b0, qx_r[DIV_STEPS]};
    magy = ctx_r[DIV_STEPS].degen ? '0 : {1'b0, qy_r[DIV_STEPS]};
    seg_out.ctx = ctx_r[DIV_STEPS];
    seg_out.mx  = ctx_r[DIV_STEPS].negx ? -$signed(magx) : $signed(magx);
    seg_out.my  = ctx_r[DIV_STEPS].negy ? -$signed(magy) : $signed(magy);
  end

  assign seg_valid = vld_r[DIV_STEPS];
endmodule

### rtl/tlqe_back.sv
// Back end: segment queue and six-vertex emitter with saturating sums.
// Depends on tlqe_pkg.
module tlqe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              seg_valid,
  input  tlqe_pkg::seg_t    seg_in,
  output logic              out_strobe,
  output tlqe_pkg::out_item_t out_item,
  output logic              seg_done
);
  import tlqe_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] res;
    if (v > 34'sd2147483647)       res = 32'sh7fffffff;
    else if (v < -34'sd2147483648) res = 32'sh80000000;
    else                           res = v[31:0];
    return res;
  endfunction

  seg_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] mcnt_r;
  seg_t             rd_data_r;
  logic             rd_valid_r;
  seg_t             cur_r;
  logic             active_r;
  logic [2:0]       k_r;
  logic             out_strobe_r;
  out_item_t        out_item_r;

  logic             last, take, pop;
  logic signed [33:0] bx, by, mx, my, px, py;

  assign last = active_r && (k_r == 3'(N_VERTS - 1));
  assign take = rd_valid_r && (!active_r || last);
  assign pop  = (mcnt_r != '0) && (!rd_valid_r || take);

  always_ff @(posedge clk) begin
    if (seg_valid) mem[wr_ptr_r] <= seg_in;
    if (pop)       rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      mcnt_r       <= '0;
      rd_valid_r   <= 1'b0;
      active_r     <= 1'b0;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (seg_valid) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)       rd_ptr_r <= rd_ptr_r + 1'b1;
      mcnt_r <= mcnt_r + CNT_W'(seg_valid) - CNT_W'(pop);
      if (pop)       rd_valid_r <= 1'b1;
      else if (take) rd_valid_r <= 1'b0;
      if (take) begin
        active_r <= 1'b1;
        k_r      <= '0;
      end else if (last) begin
        active_r <= 1'b0;
      end else if (active_r) begin
        k_r <= k_r + 1'b1;
      end
      out_strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur_r <= rd_data_r;
  end

  always_comb begin
    mx = 34'(cur_r.mx);
    my = 34'(cur_r.my);
    case (k_r) inside
      3'd0, 3'd3: begin  // start left
        bx = 34'(cur_r.ctx.sx); by = 34'(cur_r.ctx.sy);
        px = bx - mx - my;      py = by - my + mx;
      end
      3'd2: begin        // end left
        bx = 34'(cur_r.ctx.ex); by = 34'(cur_r.ctx.ey);
        px = bx + mx - my;      py = by + my + mx;
      end
      3'd4: begin        // start right
        bx = 34'(cur_r.ctx.sx); by = 34'(cur_r.ctx.sy);
        px = bx - mx + my;      py = by - my - mx;
      end
      default: begin     // end right
        bx = 34'(cur_r.ctx.ex); by = 34'(cur_r.ctx.ey);
        px = bx + mx + my;      py = by + my - mx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_item_r.pos_x       <= sat32(px);
    out_item_r.pos_y       <= sat32(py);
    out_item_r.color_out   <= cur_r.ctx.color;
    out_item_r.degenerate  <= cur_r.ctx.degen;
    out_item_r.last_vertex <= last;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
  assign seg_done   = last;
endmodule

### rtl/thick_line_quad_expander_unit.sv
// Thick line quad expander: one segment in, six vertices out.
// An accepted request passes the front end, square root, divider and queue before its first vertex strobe.
// Throughput is set by the single-vertex-per-cycle emitter;
// up to 16 requests may be in flight, then busy stays high until one finishes.
// Reset (synchronous, rst_n low) empties the pipeline and queue; results cannot be stalled.
`include "assert_macros.svh"
module thick_line_quad_expander_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tlqe_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output tlqe_pkg::out_item_t out_item
);
  import tlqe_pkg::*;

  logic             accept, seg_done;
  logic             sq_valid, rt_valid, seg_valid;
  sq_t              sq;
  rt_t              rt;
  seg_t             seg;
  logic [CNT_W-1:0] cnt_r;

  assign busy   = (cnt_r == CNT_W'(Q_DEPTH));
  assign accept = start && !busy;

  // count requests in flight so the queue can never overflow
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_r + CNT_W'(accept) - CNT_W'(seg_done);
  end

  tlqe_front u_front (
    .clk, .rst_n, .in_valid(accept), .in_item, .sq_valid, .sq_out(sq)
  );

  tlqe_sqrt u_sqrt (
    .clk, .rst_n, .sq_valid, .sq_in(sq), .rt_valid, .rt_out(rt)
  );

  tlqe_div u_div (
    .clk, .rst_n, .rt_valid, .rt_in(rt), .seg_valid, .seg_out(seg)
  );

  tlqe_back u_back (
    .clk, .rst_n, .seg_valid, .seg_in(seg), .out_strobe, .out_item, .seg_done
  );

  `ASSERT_NEVER(a_cnt_range, cnt_r > CNT_W'(Q_DEPTH), "in-flight count exceeds queue depth")
  `ASSERT_CLK(a_accept_counts, accept |=> cnt_r != '0, "accepted request not counted")
  `ASSERT_NEVER(a_last_strobe, out_item.last_vertex && !out_strobe, "last vertex without strobe")
endmodule
